// ===== hw/rtl/bnls_pkg.sv =====
// Shared types, constants and helpers for the blended normal light shader.
package bnls_pkg;

  typedef struct packed {
    logic signed [7:0] normal_x;
    logic signed [7:0] normal_y;
    logic signed [7:0] normal_z;
  } pix_in_t;

  typedef struct packed {
    logic       pixel_on;
    logic [7:0] lit_level;
    logic [7:0] luminance;
    logic       in_band;
    logic [7:0] glow_red;
    logic [7:0] glow_green;
    logic [7:0] glow_blue;
  } pix_out_t;

  typedef struct packed {
    logic [7:0]        roundness;
    logic [6:0]        fade_half_width;
    logic [6:0]        night_floor;
    logic signed [8:0] light_x;
    logic signed [8:0] light_y;
    logic signed [6:0] light_z;
    logic [5:0]        glow_width;
    logic [8:0]        glow_peak;
  } cfg_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] CfgRoundness     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFadeHalfWidth = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNightFloor    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLightX        = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLightY        = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLightZ        = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgGlowWidth     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgGlowPeak      = 3'd7;

  localparam cfg_t CfgReset = '{
    roundness:       8'd170,
    fade_half_width: 7'd36,
    night_floor:     7'd18,
    light_x:         9'sd127,
    light_y:         9'sd0,
    light_z:         7'sd0,
    glow_width:      6'd9,
    glow_peak:       9'd200
  };

  // Divider lanes: restoring, QuoW quotient bits, DivPerStage bits per stage
  localparam int RemW        = 16;
  localparam int DenW        = 8;
  localparam int QuoW        = 10;
  localparam int DivPerStage = 2;
  localparam int DivStages   = QuoW / DivPerStage;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } dlane_t;

  typedef struct packed {
    logic zero;
    logic lit_lo;
    logic lit_hi;
    logic in_band;
  } side_t;

  typedef struct packed {
    dlane_t lit;
    dlane_t glow;
    side_t  side;
  } div_stage_t;

  // Exact x / 255 for x below 65280
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ===== hw/rtl/bnls_front.sv =====
// Front pipeline: face normal, blend, dot product, divide by 127, divider setup.
module bnls_front import bnls_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pix_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output div_stage_t out_data_o
);

  localparam int NStg = 6;
  localparam logic [13:0] Recip127 = 14'd8256;
  localparam int Recip127Sh = 20;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] v_src;
  logic [NStg:0]   rdy;
  logic [NStg-1:0] en;

  always_comb begin
    rdy[NStg] = out_ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_src = {v_q[NStg-2:0], in_valid_i};
  assign en    = rdy[NStg-1:0] & v_src;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_src[k];
        end
      end
    end
  end

  function automatic logic signed [17:0] blend_num(logic signed [7:0] p, logic sel,
                                                   logic [7:0] r);
    logic signed [17:0] fe;
    logic signed [17:0] pe;
    logic signed [17:0] we;
    logic signed [17:0] wc;
    fe = !sel ? 18'sd0 : ((p > 8'sd0) ? 18'sd127 : -18'sd127);
    pe = 18'(p);
    we = $signed({10'd0, r});
    wc = $signed({10'd0, 8'd255 - r});
    return fe * wc + pe * we;
  endfunction

  // Stage 1: dominant axis and blend numerators
  logic signed [7:0]  p [3];
  logic [7:0]         a [3];
  logic [2:0]         sel;
  logic               s1_zero_d, s1_zero_q;
  logic signed [17:0] s1_num_d [3];
  logic signed [17:0] s1_num_q [3];

  always_comb begin
    p[0] = in_data_i.normal_x;
    p[1] = in_data_i.normal_y;
    p[2] = in_data_i.normal_z;
    for (int i = 0; i < 3; i++) begin
      a[i] = p[i][7] ? 8'(-p[i]) : 8'(p[i]);
    end
    sel[0] = (a[0] >= a[1]) && (a[0] >= a[2]);
    sel[1] = !sel[0] && (a[1] >= a[2]);
    sel[2] = !sel[0] && !sel[1];
    s1_zero_d = (p[0] == 8'sd0) && (p[1] == 8'sd0) && (p[2] == 8'sd0);
    for (int i = 0; i < 3; i++) begin
      s1_num_d[i] = blend_num(p[i], sel[i], cfg_i.roundness);
    end
  end

  // Stage 2: divide by 255 toward zero
  logic              s2_zero_q;
  logic signed [8:0] s2_n_d [3];
  logic signed [8:0] s2_n_q [3];

  always_comb begin
    logic [17:0]       mag;
    logic signed [8:0] nq;
    for (int i = 0; i < 3; i++) begin
      mag = s1_num_q[i][17] ? 18'(-s1_num_q[i]) : 18'(s1_num_q[i]);
      nq  = $signed({1'b0, div255(mag[15:0])});
      s2_n_d[i] = s1_num_q[i][17] ? -nq : nq;
    end
  end

  // Stage 3: dot product
  logic               s3_zero_q;
  logic signed [19:0] s3_sum_d, s3_sum_q;

  assign s3_sum_d = 20'(s2_n_q[0]) * 20'(cfg_i.light_x)
                  + 20'(s2_n_q[1]) * 20'(cfg_i.light_y)
                  + 20'(s2_n_q[2]) * 20'(cfg_i.light_z);

  // Stage 4: magnitude and reciprocal estimate of /127
  logic        s4_zero_q;
  logic        s4_neg_q;
  logic [16:0] s4_mag_d, s4_mag_q;
  logic [30:0] s4_prod;
  logic [9:0]  s4_q0_d, s4_q0_q;

  always_comb begin
    s4_mag_d = s3_sum_q[19] ? 17'(-s3_sum_q) : 17'(s3_sum_q);
    s4_prod  = 31'(s4_mag_d) * 31'(Recip127);
    s4_q0_d  = s4_prod[Recip127Sh+9:Recip127Sh];
  end

  // Stage 5: one-step correction, signed quotient
  logic               s5_zero_q;
  logic [16:0]        s5_rem;
  logic [9:0]         s5_qq;
  logic signed [10:0] s5_d_d, s5_d_q;

  always_comb begin
    s5_rem = s4_mag_q - 17'(s4_q0_q) * 17'd127;
    s5_qq  = s4_q0_q + 10'(s5_rem >= 17'd127);
    s5_d_d = s4_neg_q ? -$signed({1'b0, s5_qq}) : $signed({1'b0, s5_qq});
  end

  // Stage 6: ramp and glow divider setup
  div_stage_t         s6_d, s6_q;
  logic [6:0]         fade;
  logic signed [10:0] fades;
  logic signed [11:0] u;
  logic [7:0]         u8;
  logic [9:0]         ad;
  logic [5:0]         gdiff;
  logic               mid;

  always_comb begin
    fade  = (cfg_i.fade_half_width == 7'd0) ? 7'd1 : cfg_i.fade_half_width;
    fades = $signed({4'd0, fade});
    u     = 12'(s5_d_q) + 12'(fades);
    u8    = u[7:0];
    ad    = s5_d_q[10] ? 10'(-s5_d_q) : 10'(s5_d_q);
    gdiff = cfg_i.glow_width - ad[5:0];

    s6_d.side.zero    = s5_zero_q;
    s6_d.side.lit_lo  = (u <= 12'sd0);
    s6_d.side.lit_hi  = (s5_d_q >= fades);
    s6_d.side.in_band = ({4'd0, cfg_i.glow_width} > ad);
    mid = !s6_d.side.lit_lo && !s6_d.side.lit_hi;

    s6_d.lit.rem  = mid ? ({u8, 8'd0} - {8'd0, u8}) : '0;
    s6_d.lit.den  = {fade, 1'b0};
    s6_d.lit.quo  = '0;
    s6_d.glow.rem = s6_d.side.in_band ? 16'(15'(gdiff) * 15'(cfg_i.glow_peak)) : '0;
    s6_d.glow.den = {2'd0, cfg_i.glow_width};
    s6_d.glow.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_zero_q <= s1_zero_d;
      s1_num_q  <= s1_num_d;
    end
    if (en[1]) begin
      s2_zero_q <= s1_zero_q;
      s2_n_q    <= s2_n_d;
    end
    if (en[2]) begin
      s3_zero_q <= s2_zero_q;
      s3_sum_q  <= s3_sum_d;
    end
    if (en[3]) begin
      s4_zero_q <= s3_zero_q;
      s4_neg_q  <= s3_sum_q[19];
      s4_mag_q  <= s4_mag_d;
      s4_q0_q   <= s4_q0_d;
    end
    if (en[4]) begin
      s5_zero_q <= s4_zero_q;
      s5_d_q    <= s5_d_d;
    end
    if (en[5]) begin
      s6_q <= s6_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NStg-1];
  assign out_data_o  = s6_q;

endmodule

// ===== hw/rtl/bnls_div.sv =====
// Pipelined two-lane restoring divider for the lit ramp and the glow amount.
module bnls_div import bnls_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  div_stage_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output div_stage_t out_data_o
);

  function automatic dlane_t div_step(dlane_t l, logic [3:0] sh);
    logic [RemW+1:0] cmp;
    logic [RemW+1:0] rem;
    dlane_t          o;
    cmp   = (RemW+2)'(l.den) << sh;
    rem   = (RemW+2)'(l.rem);
    o     = l;
    o.quo = {l.quo[QuoW-2:0], 1'b0};
    if (rem >= cmp) begin
      o.rem    = RemW'(rem - cmp);
      o.quo[0] = 1'b1;
    end
    return o;
  endfunction

  logic [DivStages-1:0] v_q;
  logic [DivStages-1:0] v_src;
  logic [DivStages:0]   rdy;
  div_stage_t           stg_q [DivStages];

  always_comb begin
    rdy[DivStages] = out_ready_i;
    for (int k = DivStages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_src = {v_q[DivStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < DivStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_src[k];
        end
      end
    end
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_stg
    div_stage_t src;
    div_stage_t stg_d;

    if (k == 0) begin : g_first
      assign src = in_data_i;
    end else begin : g_rest
      assign src = stg_q[k-1];
    end

    always_comb begin
      stg_d = src;
      for (int j = 0; j < DivPerStage; j++) begin
        stg_d.lit  = div_step(stg_d.lit, 4'(QuoW - 1 - k * DivPerStage - j));
        stg_d.glow = div_step(stg_d.glow, 4'(QuoW - 1 - k * DivPerStage - j));
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_src[k]) begin
        stg_q[k] <= stg_d;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[DivStages-1];
  assign out_data_o  = stg_q[DivStages-1];

endmodule

// ===== hw/rtl/bnls_back.sv =====
// Back pipeline: lit clamp, glow colors, luminance and output register.
module bnls_back import bnls_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  div_stage_t in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pix_out_t   out_data_o
);

  localparam int NStg = 2;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] v_src;
  logic [NStg:0]   rdy;

  always_comb begin
    rdy[NStg] = out_ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_src = {v_q[NStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_src[k];
        end
      end
    end
  end

  // Stage 1
  logic        b1_zero_q;
  logic        b1_band_q;
  logic [7:0]  b1_lit_d, b1_lit_q;
  logic [15:0] b1_prod_d, b1_prod_q;
  logic [7:0]  b1_red_d, b1_red_q;
  logic [7:0]  b1_green_d, b1_green_q;
  logic [7:0]  b1_blue_d, b1_blue_q;
  logic [8:0]  g;
  logic [10:0] g3;
  logic [19:0] gb;

  always_comb begin
    if (in_data_i.side.lit_lo) begin
      b1_lit_d = 8'd0;
    end else if (in_data_i.side.lit_hi) begin
      b1_lit_d = 8'd255;
    end else begin
      b1_lit_d = in_data_i.lit.quo[7:0];
    end
    b1_prod_d = 16'(b1_lit_d) * 16'(8'd255 - {1'b0, cfg_i.night_floor});

    g  = in_data_i.glow.quo[8:0];
    g3 = 11'(g) * 11'd3;
    gb = 20'(g) * 20'd683;
    b1_red_d   = (g > 9'd255) ? 8'd255 : g[7:0];
    b1_green_d = (g3[10:2] > 9'd255) ? 8'd255 : g3[9:2];
    b1_blue_d  = gb[18:11];
    if (!in_data_i.side.in_band) begin
      b1_red_d   = 8'd0;
      b1_green_d = 8'd0;
      b1_blue_d  = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && v_src[0]) begin
      b1_zero_q  <= in_data_i.side.zero;
      b1_band_q  <= in_data_i.side.in_band;
      b1_lit_q   <= b1_lit_d;
      b1_prod_q  <= b1_prod_d;
      b1_red_q   <= b1_red_d;
      b1_green_q <= b1_green_d;
      b1_blue_q  <= b1_blue_d;
    end
  end

  // Stage 2: output register
  pix_out_t   out_d, out_q;
  logic [8:0] l0;
  logic [8:0] lb;

  always_comb begin
    l0 = 9'(cfg_i.night_floor) + 9'(div255(b1_prod_q));
    lb = b1_band_q ? ((l0 + 9'd255) >> 1) : l0;
    out_d.pixel_on   = 1'b1;
    out_d.lit_level  = b1_lit_q;
    out_d.luminance  = (lb > 9'd255) ? 8'd255 : lb[7:0];
    out_d.in_band    = b1_band_q;
    out_d.glow_red   = b1_red_q;
    out_d.glow_green = b1_green_q;
    out_d.glow_blue  = b1_blue_q;
    if (b1_zero_q) begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_src[1]) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NStg-1];
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/blended_normal_light_shader.sv =====
// Top level of the blended normal light shader: config registers and pipeline.
//
// Per-pixel diffuse shading. Each transfer on the input channel (in_valid_i /
// in_ready_o, payload in_data_i) carries one signed normal; each transfer on
// the output channel (out_valid_o / out_ready_i, payload out_data_o) carries
// the lit level, luminance and glow amounts for it, in input order.
// Registers are written on the cfg channel (cfg_valid_i / cfg_ready_o,
// cfg_index_i, cfg_data_i); cfg_ready_o is always high. Write them only while
// no pixel is in flight.
// The pipeline has 13 register stages: 6 front (blend, dot product, divide by
// 127), 5 divider (two quotient bits per stage for both the ramp and glow
// divisions), 2 back.
// Throughput is one pixel per cycle while out_ready_i is high. Every stage
// has its own valid bit and loads whenever the stage ahead of it is empty or
// moving, so a stalled receiver stops only the occupied stages and bubbles
// are squeezed out.
// Reset clears all valid bits and loads the register defaults.
module blended_normal_light_shader import bnls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pix_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pix_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRoundness:     cfg_q.roundness       <= cfg_data_i[7:0];
        CfgFadeHalfWidth: cfg_q.fade_half_width <= cfg_data_i[6:0];
        CfgNightFloor:    cfg_q.night_floor     <= cfg_data_i[6:0];
        CfgLightX:        cfg_q.light_x         <= $signed(cfg_data_i[8:0]);
        CfgLightY:        cfg_q.light_y         <= $signed(cfg_data_i[8:0]);
        CfgLightZ:        cfg_q.light_z         <= $signed(cfg_data_i[6:0]);
        CfgGlowWidth:     cfg_q.glow_width      <= cfg_data_i[5:0];
        CfgGlowPeak:      cfg_q.glow_peak       <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic       fr_valid, fr_ready;
  div_stage_t fr_data;
  logic       dv_valid, dv_ready;
  div_stage_t dv_data;

  bnls_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(fr_valid),
    .out_ready_i(fr_ready),
    .out_data_o (fr_data)
  );

  bnls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fr_valid),
    .in_ready_o (fr_ready),
    .in_data_i  (fr_data),
    .out_valid_o(dv_valid),
    .out_ready_i(dv_ready),
    .out_data_o (dv_data)
  );

  bnls_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (dv_valid),
    .in_ready_o (dv_ready),
    .in_data_i  (dv_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
